@@ hdl/vfcm_pkg.sv @@
// ============================================================================
// vfcm_pkg
// Shared widths, request codes, face codes and the face corner table of the
// voxel face culling mesher.
// ============================================================================
package vfcm_pkg;

    // default chunk edge length in voxels
    localparam int MAX_SIDE_DEF = 16;

    // field widths
    localparam int MODE_W  = 2;
    localparam int COORD_W = 4;
    localparam int VERT_W  = 5;
    localparam int TYPE_W  = 8;
    localparam int FACE_W  = 3;
    localparam int IDX_W   = 18;
    localparam int SIDE_W  = 5;   // side_length register
    localparam int SUSE_W  = 6;   // saturated side, holds up to 32

    localparam int NFACE = 6;
    localparam int NVERT = 6;

    typedef logic [TYPE_W-1:0]  t_type;
    typedef logic [IDX_W-1:0]   t_vidx;
    typedef logic [SUSE_W-1:0]  t_side;

    // request codes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MESH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // face codes, also the neighbor test order
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;  // +y
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;  // -y
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd2;  // -x
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd3;  // +x
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd4;  // -z
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd5;  // +z

    // reset contents of the store and the side register
    localparam t_type                SOLID_RESET = 8'd1;
    localparam logic [SIDE_W-1:0]    SIDE_RESET  = 5'd16;

    // corner offsets per face and vertex, packed as {dx, dy, dz}
    localparam logic [2:0] CORNER [0:NFACE-1][0:NVERT-1] = '{
        '{3'b010, 3'b011, 3'b111, 3'b010, 3'b111, 3'b110},
        '{3'b000, 3'b101, 3'b001, 3'b000, 3'b100, 3'b101},
        '{3'b000, 3'b011, 3'b010, 3'b000, 3'b001, 3'b011},
        '{3'b100, 3'b110, 3'b111, 3'b100, 3'b111, 3'b101},
        '{3'b000, 3'b010, 3'b110, 3'b000, 3'b110, 3'b100},
        '{3'b001, 3'b111, 3'b011, 3'b001, 3'b101, 3'b111}
    };

endpackage

@@ hdl/vfcm_in_if.sv @@
// ============================================================================
// vfcm_in_if
// Request channel: valid/ready handshake with the request payload.
// ============================================================================
interface vfcm_in_if;

    logic                             valid;
    logic                             ready;
    logic [vfcm_pkg::MODE_W-1:0]      mode;
    logic [vfcm_pkg::COORD_W-1:0]     pos_x;
    logic [vfcm_pkg::COORD_W-1:0]     pos_y;
    logic [vfcm_pkg::COORD_W-1:0]     pos_z;
    logic [vfcm_pkg::TYPE_W-1:0]      new_type;

    modport source (
        output valid, mode, pos_x, pos_y, pos_z, new_type,
        input  ready
    );

    modport sink (
        input  valid, mode, pos_x, pos_y, pos_z, new_type,
        output ready
    );

endinterface

@@ hdl/vfcm_out_if.sv @@
// ============================================================================
// vfcm_out_if
// Vertex channel: valid/ready handshake with one vertex or marker per beat.
// ============================================================================
interface vfcm_out_if;

    logic                             valid;
    logic                             ready;
    logic [vfcm_pkg::VERT_W-1:0]      vert_x;
    logic [vfcm_pkg::VERT_W-1:0]      vert_y;
    logic [vfcm_pkg::VERT_W-1:0]      vert_z;
    logic [vfcm_pkg::TYPE_W-1:0]      cell_type;
    logic [vfcm_pkg::FACE_W-1:0]      face_id;
    logic                             vertex_valid;
    logic [vfcm_pkg::IDX_W-1:0]       vertex_index;
    logic                             last;

    modport source (
        output valid, vert_x, vert_y, vert_z, cell_type, face_id,
               vertex_valid, vertex_index, last,
        input  ready
    );

    modport sink (
        input  valid, vert_x, vert_y, vert_z, cell_type, face_id,
               vertex_valid, vertex_index, last,
        output ready
    );

endinterface

@@ hdl/vfcm_voxel_ram.sv @@
// ============================================================================
// vfcm_voxel_ram
// Voxel type store: one write port, one read port, registered read data.
// ============================================================================
module vfcm_voxel_ram #(
    parameter int DEPTH = vfcm_pkg::MAX_SIDE_DEF ** 3,
    parameter int AW    = 12
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [vfcm_pkg::TYPE_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [vfcm_pkg::TYPE_W-1:0]  o_rdata
);

    logic [vfcm_pkg::TYPE_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

@@ hdl/vfcm_ctrl.sv @@
// ============================================================================
// vfcm_ctrl
// Request sequencer: store clearing pass, voxel writes, neighbor scan through
// the store read port, face vertex emission and the output register.
// ============================================================================
module vfcm_ctrl #(
    parameter int MAX_SIDE = vfcm_pkg::MAX_SIDE_DEF,
    parameter int DEPTH    = vfcm_pkg::MAX_SIDE_DEF ** 3,
    parameter int AW       = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    vfcm_in_if.sink                      i_in,
    vfcm_out_if.source                   o_out,
    input  vfcm_pkg::t_side              i_side,
    output logic                         o_ram_we,
    output logic [AW-1:0]                o_ram_waddr,
    output vfcm_pkg::t_type              o_ram_wdata,
    output logic                         o_ram_re,
    output logic [AW-1:0]                o_ram_raddr,
    input  vfcm_pkg::t_type              i_ram_rdata
);

    // state codes
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_MARK   = 3'd5;

    localparam logic [2:0] LAST_VERT = 3'(vfcm_pkg::NVERT - 1);
    localparam logic [2:0] LAST_STEP = 3'(vfcm_pkg::NFACE);

    // store address: x + MAX_SIDE*z + MAX_SIDE*MAX_SIDE*y
    function automatic logic [AW-1:0] addr_of(input logic [4:0] x,
                                              input logic [4:0] y,
                                              input logic [4:0] z);
        return AW'(x) + AW'(MAX_SIDE) * AW'(z) + AW'(MAX_SIDE * MAX_SIDE) * AW'(y);
    endfunction

    // lowest set face bit
    function automatic logic [2:0] lowest(input logic [5:0] v);
        logic [2:0] res;
        res = '0;
        for (int i = 5; i >= 0; i--) begin
            if (v[i]) begin
                res = 3'(i);
            end
        end
        return res;
    endfunction

    logic [2:0]              r_state, n_state;
    logic [AW-1:0]           r_clr_addr, n_clr_addr;
    logic [3:0]              r_x, r_y, r_z, n_x, n_y, n_z;
    logic [2:0]              r_step, n_step;
    logic                    r_pend_oob, n_pend_oob;
    vfcm_pkg::t_type         r_type, n_type;
    logic [5:0]              r_empty, n_empty;
    logic [2:0]              r_face, n_face;
    logic [2:0]              r_vert, n_vert;
    vfcm_pkg::t_vidx         r_count, n_count;

    // output register
    logic                    r_out_valid;
    logic [4:0]              r_vx, r_vy, r_vz;
    vfcm_pkg::t_type         r_otype;
    logic [2:0]              r_oface;
    logic                    r_ovalid;
    vfcm_pkg::t_vidx         r_oidx;
    logic                    r_olast;

    logic                    can_load;
    logic                    load_vtx;
    logic                    load_mark;
    logic                    req_inside;
    logic [4:0]              nb_x, nb_y, nb_z;
    logic                    nb_oob;
    logic [5:0]              m_hi;
    logic [2:0]              cur_corner;

    assign i_in.ready = (r_state == ST_IDLE);
    assign can_load   = !r_out_valid || o_out.ready;

    assign req_inside = ({2'b00, i_in.pos_x} < i_side) && ({2'b00, i_in.pos_y} < i_side)
                     && ({2'b00, i_in.pos_z} < i_side);

    // neighbor of the held voxel for the face being scanned
    always_comb begin
        nb_x   = {1'b0, r_x};
        nb_y   = {1'b0, r_y};
        nb_z   = {1'b0, r_z};
        nb_oob = 1'b1;
        unique case (r_step)
            vfcm_pkg::FACE_TOP: begin
                nb_y   = {1'b0, r_y} + 5'd1;
                nb_oob = ({1'b0, nb_y} >= i_side);
            end
            vfcm_pkg::FACE_BOTTOM: begin
                nb_y   = {1'b0, r_y} - 5'd1;
                nb_oob = (r_y == '0);
            end
            vfcm_pkg::FACE_LEFT: begin
                nb_x   = {1'b0, r_x} - 5'd1;
                nb_oob = (r_x == '0);
            end
            vfcm_pkg::FACE_RIGHT: begin
                nb_x   = {1'b0, r_x} + 5'd1;
                nb_oob = ({1'b0, nb_x} >= i_side);
            end
            vfcm_pkg::FACE_BACK: begin
                nb_z   = {1'b0, r_z} - 5'd1;
                nb_oob = (r_z == '0);
            end
            vfcm_pkg::FACE_FRONT: begin
                nb_z   = {1'b0, r_z} + 5'd1;
                nb_oob = ({1'b0, nb_z} >= i_side);
            end
            default: nb_oob = 1'b1;
        endcase
    end

    // exposed faces after the current one
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            m_hi[i] = r_empty[i] && (3'(i) > r_face);
        end
    end

    assign cur_corner = vfcm_pkg::CORNER[r_face][r_vert];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_step      = r_step;
        n_pend_oob  = r_pend_oob;
        n_type      = r_type;
        n_empty     = r_empty;
        n_face      = r_face;
        n_vert      = r_vert;
        n_count     = r_count;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_clr_addr;
        o_ram_wdata = vfcm_pkg::SOLID_RESET;
        o_ram_re    = 1'b0;
        o_ram_raddr = addr_of(nb_x, nb_y, nb_z);
        load_vtx    = 1'b0;
        load_mark   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                // fill every entry with solid type one
                o_ram_we   = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.mode)
                        vfcm_pkg::MODE_WRITE: begin
                            o_ram_we    = req_inside;
                            o_ram_waddr = addr_of({1'b0, i_in.pos_x}, {1'b0, i_in.pos_y},
                                                  {1'b0, i_in.pos_z});
                            o_ram_wdata = i_in.new_type;
                        end
                        vfcm_pkg::MODE_MESH: begin
                            n_x        = i_in.pos_x;
                            n_y        = i_in.pos_y;
                            n_z        = i_in.pos_z;
                            n_step     = '0;
                            n_pend_oob = 1'b0;
                            if (req_inside) begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = addr_of({1'b0, i_in.pos_x}, {1'b0, i_in.pos_y},
                                                      {1'b0, i_in.pos_z});
                                n_state     = ST_SCAN;
                            end else begin
                                n_type  = '0;
                                n_state = ST_MARK;
                            end
                        end
                        vfcm_pkg::MODE_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // step 0 returns the center, steps 1..6 the neighbors
                if (r_step == '0) begin
                    n_type = i_ram_rdata;
                end
                for (int i = 0; i < 6; i++) begin
                    if (r_step == 3'(i + 1)) begin
                        n_empty[i] = r_pend_oob || (i_ram_rdata == '0);
                    end
                end
                if (r_step != LAST_STEP) begin
                    o_ram_re   = !nb_oob;
                    n_pend_oob = nb_oob;
                    n_step     = r_step + 3'd1;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ((r_type != '0) && (|r_empty)) begin
                    n_face  = lowest(r_empty);
                    n_vert  = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_MARK;
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    load_vtx = 1'b1;
                    n_count  = r_count + 1'b1;
                    if (r_vert == LAST_VERT) begin
                        if (|m_hi) begin
                            n_face = lowest(m_hi);
                            n_vert = '0;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_vert = r_vert + 3'd1;
                    end
                end
            end
            ST_MARK: begin
                if (can_load) begin
                    load_mark = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
        end
    end

    // request context
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_step     <= n_step;
        r_pend_oob <= n_pend_oob;
        r_type     <= n_type;
        r_empty    <= n_empty;
        r_face     <= n_face;
        r_vert     <= n_vert;
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_vtx || load_mark) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (load_vtx) begin
            r_vx     <= {1'b0, r_x} + {4'd0, cur_corner[2]};
            r_vy     <= {1'b0, r_y} + {4'd0, cur_corner[1]};
            r_vz     <= {1'b0, r_z} + {4'd0, cur_corner[0]};
            r_otype  <= r_type;
            r_oface  <= r_face;
            r_ovalid <= 1'b1;
            r_oidx   <= r_count;
            r_olast  <= (r_vert == LAST_VERT) && !(|m_hi);
        end else if (load_mark) begin
            r_vx     <= '0;
            r_vy     <= '0;
            r_vz     <= '0;
            r_otype  <= r_type;
            r_oface  <= '0;
            r_ovalid <= 1'b0;
            r_oidx   <= r_count;
            r_olast  <= 1'b1;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.vert_x       = r_vx;
    assign o_out.vert_y       = r_vy;
    assign o_out.vert_z       = r_vz;
    assign o_out.cell_type    = r_otype;
    assign o_out.face_id      = r_oface;
    assign o_out.vertex_valid = r_ovalid;
    assign o_out.vertex_index = r_oidx;
    assign o_out.last         = r_olast;

endmodule

@@ hdl/voxel_face_culling_mesher_unit.sv @@
// ============================================================================
// voxel_face_culling_mesher_unit
// Culled-face mesher for one cubic voxel chunk held in an on-chip store.
// ============================================================================
// Usage:
//   i_in   request channel (valid/ready). mode write stores new_type at
//          (pos_x, pos_y, pos_z); mode mesh emits the exposed faces of that
//          voxel; mode clear resets the running vertex index.
//   o_out  vertex channel, one vertex per beat, last set on the final beat
//          of a mesh request. A solid voxel with no exposed face, an empty
//          voxel or a request outside the chunk gives one beat with
//          vertex_valid low.
//   i_cfg_we / i_cfg_wdata  write the side_length register; change it only
//          while no request is in flight.
// Timing: a mesh request reads the store (center plus six neighbors through
//   the single read port, registered read data), then decides and emits
//   its vertices, one vertex per cycle while the output register is free
//   or being taken.
//   Requests are handled one at a time.
// Reset: a clearing pass writes solid type one to all MAX_SIDE^3 entries,
//   one a cycle; i_in.ready stays low until it ends. side_length resets
//   to 16, the vertex index to zero.
// Stall: the output register holds a beat until taken; emission pauses
//   while it is full, and a new request is taken once emission is done.
// ============================================================================
module voxel_face_culling_mesher_unit #(
    parameter int MAX_SIDE = vfcm_pkg::MAX_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    vfcm_in_if.sink                       i_in,
    vfcm_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [vfcm_pkg::SIDE_W-1:0]   i_cfg_wdata
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [vfcm_pkg::SIDE_W-1:0] r_side;
    vfcm_pkg::t_side             side_use;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    vfcm_pkg::t_type             ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    vfcm_pkg::t_type             ram_rdata;

    // side_length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= vfcm_pkg::SIDE_RESET;
        end else if (i_cfg_we) begin
            r_side <= i_cfg_wdata;
        end
    end

    // side in use, saturated to 1..MAX_SIDE
    always_comb begin
        if (r_side == '0) begin
            side_use = vfcm_pkg::t_side'(1);
        end else if ({1'b0, r_side} > vfcm_pkg::SUSE_W'(MAX_SIDE)) begin
            side_use = vfcm_pkg::SUSE_W'(MAX_SIDE);
        end else begin
            side_use = {1'b0, r_side};
        end
    end

    vfcm_ctrl #(
        .MAX_SIDE (MAX_SIDE),
        .DEPTH    (DEPTH),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_side      (side_use),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    vfcm_voxel_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // store is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store write and read in the same cycle");

    // clearing pass blocks requests right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in.ready)
        else $error("request taken before the clearing pass");

    // a no-face marker always closes its request
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.vertex_valid |-> o_out.last && o_out.face_id == '0)
        else $error("marker beat without last");

    // store reads only for a mesh request being taken or while requests are blocked
    a_idle_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (i_in.ready && i_in.valid && i_in.mode == vfcm_pkg::MODE_MESH)
                   || !i_in.ready)
        else $error("store read outside a mesh request");

endmodule
